### src/yppr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yppr_pkg
// Shared types and constants of the YCbCr to RGB pixel unpacker.
// ----------------------------------------------------------------------------
package yppr_pkg;

  // layout codes
  localparam logic [2:0] LAYOUT_YUYV = 3'd0;
  localparam logic [2:0] LAYOUT_YVYU = 3'd1;
  localparam logic [2:0] LAYOUT_UYVY = 3'd2;
  localparam logic [2:0] LAYOUT_VYUY = 3'd3;
  localparam logic [2:0] LAYOUT_SEP  = 3'd4;
  localparam logic [2:0] LAYOUT_WORD = 3'd5;

  // register indexes
  localparam logic [2:0] REG_LAYOUT = 3'd0;
  localparam logic [2:0] REG_ASLOT  = 3'd1;
  localparam logic [2:0] REG_VR     = 3'd2;
  localparam logic [2:0] REG_UG     = 3'd3;
  localparam logic [2:0] REG_VG     = 3'd4;
  localparam logic [2:0] REG_UB     = 3'd5;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned COEF_W = 19;
  localparam int unsigned PROD_W = 28;
  localparam int unsigned SUM_W  = 29;

  localparam logic signed [COEF_W-1:0] COEF_VR_RST = 19'sd104597;
  localparam logic signed [COEF_W-1:0] COEF_UG_RST = -19'sd25675;
  localparam logic signed [COEF_W-1:0] COEF_VG_RST = -19'sd53279;
  localparam logic signed [COEF_W-1:0] COEF_UB_RST = 19'sd132201;

  localparam logic [8:0] CHROMA_OFS = 9'd127;

  localparam logic [2:0] PIX_BYTES_RGB  = 3'd3;
  localparam logic [2:0] PIX_BYTES_WORD = 3'd4;

  typedef struct packed {
    logic [2:0]               layout;
    logic [1:0]               alpha_slot;
    logic signed [COEF_W-1:0] vr;
    logic signed [COEF_W-1:0] ug;
    logic signed [COEF_W-1:0] vg;
    logic signed [COEF_W-1:0] ub;
  } yppr_cfg_t;

  // one pixel on its way into the conversion pipeline
  typedef struct packed {
    logic [7:0]  y;
    logic [7:0]  u;
    logic [7:0]  v;
    logic [31:0] word;
    logic        pass;
    logic        last;
  } yppr_task_t;

endpackage

### src/yppr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yppr_cfg
// APB register file: layout, alpha slot and the four chroma coefficients.
// ----------------------------------------------------------------------------
module yppr_cfg import yppr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output yppr_cfg_t         cfg_o
);

  yppr_cfg_t  cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_LAYOUT: cfg_d.layout     = pwdata[2:0];
        REG_ASLOT:  cfg_d.alpha_slot = pwdata[1:0];
        REG_VR:     cfg_d.vr         = pwdata[COEF_W-1:0];
        REG_UG:     cfg_d.ug         = pwdata[COEF_W-1:0];
        REG_VG:     cfg_d.vg         = pwdata[COEF_W-1:0];
        REG_UB:     cfg_d.ub         = pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.layout     <= LAYOUT_YUYV;
      cfg_q.alpha_slot <= 2'd3;
      cfg_q.vr         <= COEF_VR_RST;
      cfg_q.ug         <= COEF_UG_RST;
      cfg_q.vg         <= COEF_VG_RST;
      cfg_q.ub         <= COEF_UB_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_LAYOUT: prdata = {29'd0, cfg_q.layout};
      REG_ASLOT:  prdata = {30'd0, cfg_q.alpha_slot};
      REG_VR:     prdata = 32'(cfg_q.vr);
      REG_UG:     prdata = 32'(cfg_q.ug);
      REG_VG:     prdata = 32'(cfg_q.vg);
      REG_UB:     prdata = 32'(cfg_q.ub);
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### src/yppr_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yppr_unpack
// Input holding register; splits one word into one or two pixel tasks.
// ----------------------------------------------------------------------------
module yppr_unpack import yppr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  yppr_cfg_t  cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [63:0] in_data_i,
  output logic       task_valid_o,
  input  logic       task_ready_i,
  output yppr_task_t task_o
);

  logic        valid_q, valid_d;
  logic        second_q, second_d;
  logic [31:0] word_q;
  logic [7:0]  y_q, u_q, v_q, alpha_q;
  logic [7:0]  b [4];
  logic [7:0]  y0, y1, cu, cv;
  logic        packed_lay, legal, fire, done;
  logic [31:0] aword;

  assign packed_lay = (cfg_i.layout == LAYOUT_YUYV) || (cfg_i.layout == LAYOUT_YVYU) ||
                      (cfg_i.layout == LAYOUT_UYVY) || (cfg_i.layout == LAYOUT_VYUY);
  assign legal      = packed_lay || (cfg_i.layout == LAYOUT_SEP) ||
                      (cfg_i.layout == LAYOUT_WORD);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      b[i] = word_q[8*i +: 8];
    end
  end

  always_comb begin
    y0 = b[0]; cu = b[1]; y1 = b[2]; cv = b[3];
    unique case (cfg_i.layout)
      LAYOUT_YVYU: begin y0 = b[0]; cv = b[1]; y1 = b[2]; cu = b[3]; end
      LAYOUT_UYVY: begin cu = b[0]; y0 = b[1]; cv = b[2]; y1 = b[3]; end
      LAYOUT_VYUY: begin cv = b[0]; y0 = b[1]; cu = b[2]; y1 = b[3]; end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      aword[8*i +: 8] = (cfg_i.alpha_slot == 2'(i)) ? alpha_q : b[i];
    end
  end

  always_comb begin
    task_o.word = aword;
    task_o.pass = (cfg_i.layout == LAYOUT_WORD);
    if (packed_lay) begin
      task_o.y    = second_q ? y1 : y0;
      task_o.u    = cu;
      task_o.v    = cv;
      task_o.last = second_q;
    end else begin
      task_o.y    = y_q;
      task_o.u    = u_q;
      task_o.v    = v_q;
      task_o.last = 1'b1;
    end
  end

  assign task_valid_o = valid_q;
  assign fire         = valid_q & task_ready_i;
  assign done         = !packed_lay || second_q;
  assign in_ready_o   = !valid_q || (task_ready_i && done);

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    if (fire) begin
      if (done) begin
        valid_d  = 1'b0;
        second_d = 1'b0;
      end else begin
        second_d = 1'b1;
      end
    end
    // unused layout codes: take the word and drop it
    if (in_valid_i && in_ready_o) begin
      valid_d  = legal;
      second_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q  <= in_data_i[31:0];
      y_q     <= in_data_i[39:32];
      u_q     <= in_data_i[47:40];
      v_q     <= in_data_i[55:48];
      alpha_q <= in_data_i[63:56];
    end
  end

`ifndef NO_ASSERTIONS
  a_second_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> valid_q) else $error("second pixel pending without a held word");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !task_ready_i |=> valid_q && $stable(second_q))
    else $error("held word lost under stall");
  a_drop_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !legal |=> !valid_q)
    else $error("word with unused layout kept");
`endif

endmodule

### src/yppr_csc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yppr_csc
// Four-stage elastic color conversion: operands, products, sums, saturate.
// ----------------------------------------------------------------------------
module yppr_csc import yppr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  yppr_cfg_t   cfg_i,
  input  logic        task_valid_i,
  output logic        task_ready_o,
  input  yppr_task_t  task_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_data_o,
  output logic [2:0]  out_user_o,
  output logic        out_last_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  yppr_task_t t1_q;

  logic signed [PROD_W-1:0] pvr_q, pug_q, pvg_q, pub_q;
  logic [7:0]  y2_q;
  logic [31:0] w2_q, w3_q;
  logic        pass2_q, last2_q, pass3_q, last3_q;

  logic signed [SUM_W-1:0] sr_q, sg_q, sb_q;

  logic [31:0] o_data_q;
  logic [2:0]  o_user_q;
  logic        o_last_q;

  logic signed [8:0]        cu, cv;
  logic signed [PROD_W-1:0] pvr_d, pug_d, pvg_d, pub_d;
  logic signed [SUM_W-1:0]  ysh;
  logic [7:0]               r8, g8, b8;

  function automatic logic [7:0] sat8(input logic signed [SUM_W-1:0] s);
    logic [7:0] r;
    if (s[SUM_W-1]) begin
      r = 8'd0;
    end else if (|s[SUM_W-2:24]) begin
      r = 8'hFF;
    end else begin
      r = s[23:16];
    end
    return r;
  endfunction

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign task_ready_o = rdy1;

  // stage 2 operands
  assign cu    = $signed({1'b0, t1_q.u} - CHROMA_OFS);
  assign cv    = $signed({1'b0, t1_q.v} - CHROMA_OFS);
  assign pvr_d = PROD_W'(cfg_i.vr) * PROD_W'(cv);
  assign pug_d = PROD_W'(cfg_i.ug) * PROD_W'(cu);
  assign pvg_d = PROD_W'(cfg_i.vg) * PROD_W'(cv);
  assign pub_d = PROD_W'(cfg_i.ub) * PROD_W'(cu);

  assign ysh = $signed({5'd0, y2_q, 16'd0});

  assign r8 = sat8(sr_q);
  assign g8 = sat8(sg_q);
  assign b8 = sat8(sb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= task_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && task_valid_i) begin
      t1_q <= task_i;
    end
    if (rdy2 && v1_q) begin
      pvr_q   <= pvr_d;
      pug_q   <= pug_d;
      pvg_q   <= pvg_d;
      pub_q   <= pub_d;
      y2_q    <= t1_q.y;
      w2_q    <= t1_q.word;
      pass2_q <= t1_q.pass;
      last2_q <= t1_q.last;
    end
    if (rdy3 && v2_q) begin
      sr_q    <= ysh + SUM_W'(pvr_q);
      sg_q    <= ysh + SUM_W'(pug_q) + SUM_W'(pvg_q);
      sb_q    <= ysh + SUM_W'(pub_q);
      w3_q    <= w2_q;
      pass3_q <= pass2_q;
      last3_q <= last2_q;
    end
    if (rdy4 && v3_q) begin
      o_data_q <= pass3_q ? w3_q : {8'd0, b8, g8, r8};
      o_user_q <= pass3_q ? PIX_BYTES_WORD : PIX_BYTES_RGB;
      o_last_q <= last3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = o_data_q;
  assign out_user_o  = o_user_q;
  assign out_last_o  = o_last_q;

`ifndef NO_ASSERTIONS
  a_rgb_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && (o_user_q == PIX_BYTES_RGB) |-> (o_data_q[31:24] == 8'd0))
    else $error("rgb word with nonzero top byte");
  a_s3_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && v4_q && !out_ready_i |=> v3_q && v4_q)
    else $error("sum stage dropped under stall");
  a_out_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (o_user_q == PIX_BYTES_RGB) || (o_user_q == PIX_BYTES_WORD))
    else $error("bad byte count on output word");
`endif

endmodule

### src/yuv_packed_planar_to_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_packed_planar_to_rgb
// YCbCr (4:2:2 packed or separate samples) to RGB888, plus alpha insertion.
// ----------------------------------------------------------------------------
// The output stream carries one pixel word per cycle while it is not stalled,
// and that sets the rate: a packed 4:2:2 input word gives two pixels, and the
// next word is taken only as its second pixel moves on; a separate-sample or
// color-plus-alpha word gives one pixel and is taken every cycle. Words
// arriving while layout 6 or 7 is set are taken and dropped. Each pixel
// passes through the operand, product, sum and saturation stages behind the
// holding register, and the second pixel of a packed word follows the first.
// Stalls on the output back up through the stages without loss. Write the
// registers only while the block is idle.
module yuv_packed_planar_to_rgb import yppr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // pixel_word[31:0], sample_y[39:32], sample_u[47:40], sample_v[55:48],
  // alpha_byte[63:56]
  input  logic [63:0]       s_axis_tdata,
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // out_byte0[7:0], out_byte1[15:8], out_byte2[23:16], out_byte3[31:24]
  output logic [31:0]       m_axis_tdata,
  // pixel_bytes[2:0]
  output logic [2:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  yppr_cfg_t  cfg;
  yppr_task_t task_w;
  logic       task_valid, task_ready;

  yppr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  yppr_unpack u_unpack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .task_valid_o (task_valid),
    .task_ready_i (task_ready),
    .task_o       (task_w)
  );

  yppr_csc u_csc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .task_valid_i (task_valid),
    .task_ready_o (task_ready),
    .task_i       (task_w),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_user_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

### tb/sv/tb_yuv_packed_planar_to_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuv_packed_planar_to_rgb
// Self-checking bench for the YCbCr to RGB unpacker. Registers are set over
// APB between bursts of input words. Every accepted word is run through a
// local model of the conversion, and every output pixel is compared field by
// field with the oldest predicted pixel. A directed burst covers reset
// settings, every layout, the coefficient extremes and the unused layout
// codes. Random bursts follow under several idle and stall patterns.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [2:0] nbytes;
  logic       last;
} rgb_pixel_t;

class pixel_scoreboard;
  logic [2:0]  layout;
  logic [1:0]  alpha_slot;
  longint      k_vr;
  longint      k_ug;
  longint      k_vg;
  longint      k_ub;
  rgb_pixel_t  pending[$];
  int unsigned mismatches;
  int unsigned pixels_seen;
  int unsigned words_by_layout[8];

  function new();
    layout      = yppr_pkg::LAYOUT_YUYV;
    alpha_slot  = 2'd3;
    k_vr        = longint'(yppr_pkg::COEF_VR_RST);
    k_ug        = longint'(yppr_pkg::COEF_UG_RST);
    k_vg        = longint'(yppr_pkg::COEF_VG_RST);
    k_ub        = longint'(yppr_pkg::COEF_UB_RST);
    mismatches  = 0;
    pixels_seen = 0;
    foreach (words_by_layout[i]) words_by_layout[i] = 0;
  endfunction

  function longint coef_of(logic [31:0] val);
    logic signed [18:0] c;
    c = val[18:0];
    return longint'(c);
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      yppr_pkg::REG_LAYOUT: layout     = val[2:0];
      yppr_pkg::REG_ASLOT:  alpha_slot = val[1:0];
      yppr_pkg::REG_VR:     k_vr       = coef_of(val);
      yppr_pkg::REG_UG:     k_ug       = coef_of(val);
      yppr_pkg::REG_VG:     k_vg       = coef_of(val);
      yppr_pkg::REG_UB:     k_ub       = coef_of(val);
      default: ;
    endcase
  endfunction

  // floor of the 16.16 sum, clamped to a byte
  function logic [7:0] clamp_channel(logic [7:0] y, longint chroma);
    longint s;
    s = y;
    s = s * 65536 + chroma;
    if (s < 0) return 8'd0;
    if (s >= 64'sd16777216) return 8'd255;
    return s[23:16];
  endfunction

  function rgb_pixel_t yuv_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v, logic last);
    rgb_pixel_t px;
    longint     du;
    longint     dv;
    du = u;
    dv = v;
    du = du - 127;
    dv = dv - 127;
    px.byte0  = clamp_channel(y, k_vr * dv);
    px.byte1  = clamp_channel(y, k_ug * du + k_vg * dv);
    px.byte2  = clamp_channel(y, k_ub * du);
    px.byte3  = 8'd0;
    px.nbytes = yppr_pkg::PIX_BYTES_RGB;
    px.last   = last;
    return px;
  endfunction

  function void note_word(logic [63:0] d);
    logic [7:0] b[4];
    logic [7:0] y0;
    logic [7:0] y1;
    logic [7:0] cu;
    logic [7:0] cv;
    rgb_pixel_t px;
    int         i;
    for (i = 0; i < 4; i++) b[i] = d[8*i +: 8];
    words_by_layout[layout]++;
    case (layout)
      yppr_pkg::LAYOUT_YUYV: begin
        y0 = b[0]; cu = b[1]; y1 = b[2]; cv = b[3];
      end
      yppr_pkg::LAYOUT_YVYU: begin
        y0 = b[0]; cv = b[1]; y1 = b[2]; cu = b[3];
      end
      yppr_pkg::LAYOUT_UYVY: begin
        cu = b[0]; y0 = b[1]; cv = b[2]; y1 = b[3];
      end
      yppr_pkg::LAYOUT_VYUY: begin
        cv = b[0]; y0 = b[1]; cu = b[2]; y1 = b[3];
      end
      yppr_pkg::LAYOUT_SEP: begin
        pending.push_back(yuv_pixel(d[39:32], d[47:40], d[55:48], 1'b1));
        return;
      end
      yppr_pkg::LAYOUT_WORD: begin
        b[alpha_slot] = d[63:56];
        px.byte0  = b[0];
        px.byte1  = b[1];
        px.byte2  = b[2];
        px.byte3  = b[3];
        px.nbytes = yppr_pkg::PIX_BYTES_WORD;
        px.last   = 1'b1;
        pending.push_back(px);
        return;
      end
      default: return;  // unused codes: drop the word
    endcase
    pending.push_back(yuv_pixel(y0, cu, cv, 1'b0));
    pending.push_back(yuv_pixel(y1, cu, cv, 1'b1));
  endfunction

  function void check_pixel(logic [31:0] data, logic [2:0] user, logic last);
    rgb_pixel_t got;
    rgb_pixel_t want;
    got = {data[7:0], data[15:8], data[23:16], data[31:24], user, last};
    pixels_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected pixel %02h %02h %02h %02h bytes=%0d last=%0b",
                 $realtime, got.byte0, got.byte1, got.byte2, got.byte3,
                 got.nbytes, got.last);
      return;
    end
    want = pending.pop_front();
    if (got.byte0 !== want.byte0 || got.byte1 !== want.byte1 ||
        got.byte2 !== want.byte2 || got.byte3 !== want.byte3 ||
        got.nbytes !== want.nbytes || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: pixel %0d want %h %h %h %h n=%0d l=%0b got %h %h %h %h n=%0d l=%0b",
                 $realtime, pixels_seen, want.byte0, want.byte1, want.byte2,
                 want.byte3, want.nbytes, want.last, got.byte0, got.byte1,
                 got.byte2, got.byte3, got.nbytes, got.last);
    end
  endfunction
endclass

module tb_yuv_packed_planar_to_rgb;
  import yppr_pkg::*;

  localparam logic [2:0] LAYOUT_RSVD6 = 3'd6;
  localparam logic [2:0] LAYOUT_RSVD7 = 3'd7;
  localparam int DRAIN_CYCLES    = 20;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_BURST = 92;

  logic              clk_i;
  logic              rst_ni;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [APB_AW-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;
  logic [2:0]        m_axis_tuser;
  logic              m_axis_tlast;

  int unsigned idle_pct       = 0;
  int unsigned stall_pct      = 0;
  int unsigned settings_count = 0;

  pixel_scoreboard sb;

  yuv_packed_planar_to_rgb dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_yuv_packed_planar_to_rgb: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_pixel(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    return {rand_byte(), rand_byte(), rand_byte(), rand_byte(),
            rand_byte(), rand_byte(), rand_byte(), rand_byte()};
  endfunction

  function automatic logic [18:0] extreme_coef();
    case ($urandom_range(0, 2))
      0: return 19'h40000;
      1: return 19'h3FFFF;
      default: return 19'h00000;
    endcase
  endfunction

  // keep tvalid high across back-to-back words; drop it only for a gap
  task automatic send_word(input logic [63:0] d);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    // let the last accepted word reach the scoreboard before checking the queue
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [2:0] layout, input logic [1:0] slot,
                           input logic [18:0] vr, input logic [18:0] ug,
                           input logic [18:0] vg, input logic [18:0] ub);
    logic [31:0] vals[6];
    int          i;
    vals[REG_LAYOUT] = {29'd0, layout};
    vals[REG_ASLOT]  = {30'd0, slot};
    vals[REG_VR]     = {{13{vr[18]}}, vr};
    vals[REG_UG]     = {{13{ug[18]}}, ug};
    vals[REG_VG]     = {{13{vg[18]}}, vg};
    vals[REG_UB]     = {{13{ub[18]}}, ub};
    settle_block();
    for (i = 0; i < 6; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= APB_AW'(i * 4);
      pwdata  <= vals[i];
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      sb.set_reg(3'(i), vals[i]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_count++;
  endtask

  task automatic run_directed();
    int s;
    // reset settings: yuyv, standard coefficients
    send_word(64'h0000_0000_0000_0000);
    send_word(64'h0000_0000_FFFF_FFFF);
    send_word(64'h0000_0000_7FFF_7F00);
    send_word(64'h0000_0000_0080_FF80);
    configure(LAYOUT_YVYU, 2'd3, COEF_VR_RST, COEF_UG_RST, COEF_VG_RST, COEF_UB_RST);
    send_word(64'hFFFF_FFFF_FF00_FF00);
    configure(LAYOUT_UYVY, 2'd3, COEF_VR_RST, COEF_UG_RST, COEF_VG_RST, COEF_UB_RST);
    send_word(64'h0000_0000_1234_5678);
    configure(LAYOUT_VYUY, 2'd3, COEF_VR_RST, COEF_UG_RST, COEF_VG_RST, COEF_UB_RST);
    send_word(64'h0000_0000_8765_4321);
    // separate samples: tdata is {alpha, v, u, y, word}
    configure(LAYOUT_SEP, 2'd3, COEF_VR_RST, COEF_UG_RST, COEF_VG_RST, COEF_UB_RST);
    send_word({8'hFF, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF});
    send_word({8'h00, 8'hFF, 8'hFF, 8'hFF, 32'h0000_0000});
    send_word({8'h00, 8'h7F, 8'h7F, 8'hC8, 32'h0000_0000});
    send_word({8'h00, 8'h00, 8'hFF, 8'hFF, 32'h0000_0000});
    configure(LAYOUT_SEP, 2'd0, 19'h3FFFF, 19'h3FFFF, 19'h3FFFF, 19'h3FFFF);
    send_word({8'h00, 8'hFF, 8'h00, 8'h80, 32'h0000_0000});
    configure(LAYOUT_SEP, 2'd0, 19'h40000, 19'h40000, 19'h40000, 19'h40000);
    send_word({8'h00, 8'hFF, 8'h00, 8'h80, 32'h0000_0000});
    // alpha into each slot of the colour word
    for (s = 0; s < 4; s++) begin
      configure(LAYOUT_WORD, 2'(s), COEF_VR_RST, COEF_UG_RST, COEF_VG_RST, COEF_UB_RST);
      send_word({s[0] ? 8'hFF : 8'h00, 24'h0, 32'hA5C3_5A3C});
    end
    configure(LAYOUT_RSVD6, 2'd3, COEF_VR_RST, COEF_UG_RST, COEF_VG_RST, COEF_UB_RST);
    send_word(64'hFFFF_FFFF_FFFF_FFFF);
    configure(LAYOUT_RSVD7, 2'd3, COEF_VR_RST, COEF_UG_RST, COEF_VG_RST, COEF_UB_RST);
    send_word(64'h0000_0000_0000_0000);
  endtask

  task automatic run_burst(input int p, input logic [2:0] layout, input int count);
    logic [18:0] c[4];
    int          k;
    case (p % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 73; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 73; end
      default: begin idle_pct = 9; stall_pct = 9; end
    endcase
    for (k = 0; k < 4; k++) begin
      case (p % 3)
        0: c[k] = (k == 0) ? COEF_VR_RST : (k == 1) ? COEF_UG_RST :
                  (k == 2) ? COEF_VG_RST : COEF_UB_RST;
        1: c[k] = 19'($urandom_range(0, 524287));
        default: c[k] = extreme_coef();
      endcase
    end
    configure(layout, 2'($urandom_range(0, 3)), c[0], c[1], c[2], c[3]);
    for (k = 0; k < count; k++) begin
      send_word(rand_word());
      // hold off until the block has emptied once per burst
      if (k == count / 2) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (sb.pending.size() != 0);
      end
    end
  endtask

  initial begin
    int p;
    rst_ni <= 1'b0;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (p = 0; p < 12; p++)
      run_burst(p, (p < 6) ? 3'(p) : 3'($urandom_range(0, 5)), ITEMS_PER_BURST);
    run_burst(12, LAYOUT_RSVD6, 6);
    run_burst(13, LAYOUT_RSVD7, 6);
    run_burst(14, 3'($urandom_range(0, 5)), 40);
    settle_block();
    $display("words: yuyv %0d yvyu %0d uyvy %0d vyuy %0d sep %0d alpha %0d unused %0d",
             sb.words_by_layout[0], sb.words_by_layout[1], sb.words_by_layout[2],
             sb.words_by_layout[3], sb.words_by_layout[4], sb.words_by_layout[5],
             sb.words_by_layout[6] + sb.words_by_layout[7]);
    $display("%0d pixels checked across %0d register settings, %0d mismatches",
             sb.pixels_seen, settings_count, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_yuv_packed_planar_to_rgb: PASS");
    end else begin
      $display("tb_yuv_packed_planar_to_rgb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
src/yppr_pkg.sv
src/yppr_cfg.sv
src/yppr_unpack.sv
src/yppr_csc.sv
src/yuv_packed_planar_to_rgb.sv
tb/sv/tb_yuv_packed_planar_to_rgb.sv
